// File: hdl/suks_pkg.sv
package suks_pkg;

  typedef struct packed {
    logic [63:0] w0;
    logic [63:0] w1;
    logic [63:0] w2;
    logic [63:0] w3;
    logic [7:0]  tail;
  } key_t;

  localparam int KEY_W = $bits(key_t);

  typedef struct packed {
    key_t key;
    logic enable;
  } excl_cfg_t;

  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    key_t       wdata;
    logic [7:0] raddr;
  } mem_req_t;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_EXCLUDED  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_CLEARED   = 3'd4;
  localparam logic [2:0] ST_READ_OK   = 3'd5;
  localparam logic [2:0] ST_BAD_INDEX = 3'd6;

  localparam logic [2:0] REG_EXCL_WORD0 = 3'd0;
  localparam logic [2:0] REG_EXCL_WORD1 = 3'd1;
  localparam logic [2:0] REG_EXCL_WORD2 = 3'd2;
  localparam logic [2:0] REG_EXCL_WORD3 = 3'd3;
  localparam logic [2:0] REG_EXCL_TAIL  = 3'd4;
  localparam logic [2:0] REG_EXCL_EN    = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_SHIFT,
    S_PLACE,
    S_RDATA,
    S_OUT
  } state_t;

endpackage

// File: hdl/suks_ram.sv
module suks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_r <= mem_q[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/suks_ctrl.sv
module suks_ctrl #(
  parameter int MAX_KEYS = 255
) (
  input  logic                clk,
  input  logic                rst_n,
  input  suks_pkg::excl_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_opcode,
  input  suks_pkg::key_t      in_key,
  input  logic [7:0]          in_read_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output suks_pkg::key_t      out_key,
  output logic [7:0]          out_held,
  output logic                out_ovf,
  output suks_pkg::mem_req_t  mem_req,
  input  suks_pkg::key_t      mem_rdata
);

  import suks_pkg::*;

  localparam logic [7:0] MAX_CNT = 8'(MAX_KEYS);

  state_t     state_r, state_nxt;
  logic [7:0] count_r, count_nxt;
  logic       ovf_r, ovf_nxt;
  logic [7:0] idx_r, idx_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] sh_src_r, sh_src_nxt;
  logic       sh_pend_r, sh_pend_nxt;
  logic       sh_done_r, sh_done_nxt;
  key_t       key_r, key_nxt;
  logic [2:0] st_r, st_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_status_r, out_status_nxt;
  key_t       out_key_r, out_key_nxt;
  logic [7:0] out_held_r, out_held_nxt;
  logic       out_ovf_r, out_ovf_nxt;

  logic       in_xfer;
  logic       slot_free;
  logic       rd_ok;
  logic       excl_hit;
  logic       key_eq;
  logic       key_lt;
  logic       is_full;
  logic [7:0] idx_inc;
  logic       scan_last;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign rd_ok     = (in_read_index < count_r);
  assign excl_hit  = cfg.enable && (key_r == cfg.key);
  assign key_eq    = (key_r == mem_rdata);
  assign key_lt    = (key_r < mem_rdata);
  assign is_full   = (count_r >= MAX_CNT);
  assign idx_inc   = idx_r + 8'd1;
  assign scan_last = (idx_inc == count_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_opcode)
            OP_CLEAR:  state_nxt = S_OUT;
            OP_INSERT: state_nxt = S_CHECK;
            OP_READ:   state_nxt = rd_ok ? S_RDATA : S_OUT;
            default:   state_nxt = S_OUT;
          endcase
        end
      end
      S_CHECK: begin
        if (excl_hit) begin
          state_nxt = S_OUT;
        end else if (count_r == 8'd0) begin
          state_nxt = S_PLACE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (key_eq) begin
          state_nxt = S_OUT;
        end else if (key_lt) begin
          state_nxt = is_full ? S_OUT : S_SHIFT;
        end else if (scan_last) begin
          state_nxt = is_full ? S_OUT : S_PLACE;
        end
      end
      S_SHIFT: begin
        if (sh_done_r) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: state_nxt = S_OUT;
      S_RDATA, S_OUT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    sh_src_nxt     = sh_src_r;
    sh_pend_nxt    = sh_pend_r;
    sh_done_nxt    = sh_done_r;
    key_nxt        = key_r;
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_held_nxt   = out_held_r;
    out_ovf_nxt    = out_ovf_r;
    mem_req.we     = 1'b0;
    mem_req.waddr  = pos_r;
    mem_req.wdata  = key_r;
    mem_req.raddr  = idx_r;
    unique case (state_r)
      S_IDLE: begin
        mem_req.raddr = in_read_index;
        if (in_xfer) begin
          key_nxt = in_key;
          idx_nxt = in_read_index;
          unique case (in_opcode)
            OP_CLEAR: begin
              count_nxt = 8'd0;
              ovf_nxt   = 1'b0;
              st_nxt    = ST_CLEARED;
            end
            OP_INSERT: st_nxt = ST_INSERTED;
            OP_READ:   st_nxt = rd_ok ? ST_READ_OK : ST_BAD_INDEX;
            default:   st_nxt = ST_BAD_INDEX;
          endcase
        end
      end
      S_CHECK: begin
        mem_req.raddr = 8'd0;
        idx_nxt       = 8'd0;
        pos_nxt       = 8'd0;
        if (excl_hit) begin
          st_nxt = ST_EXCLUDED;
        end
      end
      S_SCAN: begin
        // rdata holds entry idx_r; fetch the next one speculatively
        mem_req.raddr = idx_inc;
        if (key_eq) begin
          st_nxt = ST_DUPLICATE;
        end else if (key_lt || scan_last) begin
          pos_nxt = key_lt ? idx_r : count_r;
          if (is_full) begin
            st_nxt  = ST_FULL;
            ovf_nxt = 1'b1;
          end else begin
            idx_nxt     = count_r - 8'd1;
            sh_pend_nxt = 1'b0;
            sh_done_nxt = 1'b0;
          end
        end else begin
          idx_nxt = idx_inc;
        end
      end
      S_SHIFT: begin
        // read entry idx_r while writing the previous one up by a slot
        mem_req.raddr = idx_r;
        mem_req.we    = sh_pend_r;
        mem_req.waddr = sh_src_r + 8'd1;
        mem_req.wdata = mem_rdata;
        if (!sh_done_r) begin
          sh_src_nxt  = idx_r;
          sh_pend_nxt = 1'b1;
          if (idx_r == pos_r) begin
            sh_done_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r - 8'd1;
          end
        end else begin
          sh_pend_nxt = 1'b0;
        end
      end
      S_PLACE: begin
        mem_req.we = 1'b1;
        count_nxt  = count_r + 8'd1;
        st_nxt     = ST_INSERTED;
      end
      S_RDATA: begin
        mem_req.raddr = idx_r;
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_READ_OK;
          out_key_nxt    = mem_rdata;
          out_held_nxt   = count_r;
          out_ovf_nxt    = ovf_r;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_key_nxt    = '0;
          out_held_nxt   = count_r;
          out_ovf_nxt    = ovf_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= 8'd0;
      ovf_r       <= 1'b0;
      sh_pend_r   <= 1'b0;
      sh_done_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      sh_pend_r   <= sh_pend_nxt;
      sh_done_r   <= sh_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    sh_src_r     <= sh_src_nxt;
    key_r        <= key_nxt;
    st_r         <= st_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_held_r   <= out_held_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_key    = out_key_r;
  assign out_held   = out_held_r;
  assign out_ovf    = out_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("key count above capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (count_r == MAX_CNT))
    else $error("overflow flag set below capacity");

  a_shift_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) && mem_req.we |-> (mem_req.waddr != mem_req.raddr))
    else $error("shift write hits the entry being read");

  a_place_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLACE) |=> (count_r == $past(count_r) + 8'd1))
    else $error("placement did not bump count");

endmodule

// File: hdl/sorted_unique_key_set.sv
// Sorted set of unique 33-byte keys.
// Input channel (in_valid/in_ready): opcode clear, insert or read, with the
// key (four 64-bit words, word0 most significant, plus a tail byte) and a
// read index. One result per input on the out_ channel (out_valid/out_ready):
// status, read entry (zero unless read ok), key count and sticky overflow.
// Configuration sits on the cfg_ APB port, one 64-bit register every 8 bytes.
// Items are handled one at a time out of a single-port-write RAM.
// Clear and read: S_OUT (clear) or S_RDATA (read) loads the result into the output register.
// Insert: an exclusion check, a scan of the entries up to the first key that
// is not smaller, then the larger entries moved up a slot one by one, a
// placement step and an output step; an excluded or duplicate key, or one
// that finds the set full, goes straight to the output step.
// The output register holds a result while out_ready is low; the next item
// is taken meanwhile, but its result waits for the output register.
// Reset empties the set and clears the overflow flag; RAM contents are not
// cleared, and entries at or above the key count may be read but are never used.
module sorted_unique_key_set #(
  parameter int MAX_KEYS = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [63:0] in_key_word0,
  input  logic [63:0] in_key_word1,
  input  logic [63:0] in_key_word2,
  input  logic [63:0] in_key_word3,
  input  logic [7:0]  in_key_tail,
  input  logic [7:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [63:0] out_word0,
  output logic [63:0] out_word1,
  output logic [63:0] out_word2,
  output logic [63:0] out_word3,
  output logic [7:0]  out_tail,
  output logic [7:0]  out_stored_count,
  output logic        out_overflowed,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  import suks_pkg::*;

  localparam int ADDR_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  excl_cfg_t cfg_r;
  logic      cfg_wr;
  logic [2:0] cfg_idx;
  key_t      in_key;
  key_t      out_key;
  mem_req_t  mem_req;
  key_t      mem_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key    <= '0;
      cfg_r.enable <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_EXCL_WORD0: cfg_r.key.w0   <= cfg_pwdata;
        REG_EXCL_WORD1: cfg_r.key.w1   <= cfg_pwdata;
        REG_EXCL_WORD2: cfg_r.key.w2   <= cfg_pwdata;
        REG_EXCL_WORD3: cfg_r.key.w3   <= cfg_pwdata;
        REG_EXCL_TAIL:  cfg_r.key.tail <= cfg_pwdata[7:0];
        REG_EXCL_EN:    cfg_r.enable   <= cfg_pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_EXCL_WORD0: cfg_prdata = cfg_r.key.w0;
      REG_EXCL_WORD1: cfg_prdata = cfg_r.key.w1;
      REG_EXCL_WORD2: cfg_prdata = cfg_r.key.w2;
      REG_EXCL_WORD3: cfg_prdata = cfg_r.key.w3;
      REG_EXCL_TAIL:  cfg_prdata = {56'd0, cfg_r.key.tail};
      REG_EXCL_EN:    cfg_prdata = {63'd0, cfg_r.enable};
      default:        cfg_prdata = 64'd0;
    endcase
  end

  assign in_key.w0   = in_key_word0;
  assign in_key.w1   = in_key_word1;
  assign in_key.w2   = in_key_word2;
  assign in_key.w3   = in_key_word3;
  assign in_key.tail = in_key_tail;

  suks_ctrl #(
    .MAX_KEYS(MAX_KEYS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_key       (in_key),
    .in_read_index(in_read_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_key      (out_key),
    .out_held     (out_stored_count),
    .out_ovf      (out_overflowed),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata)
  );

  suks_ram #(
    .WIDTH(KEY_W),
    .DEPTH(MAX_KEYS)
  ) u_ram (
    .clk  (clk),
    .we   (mem_req.we),
    .waddr(mem_req.waddr[ADDR_W-1:0]),
    .wdata(mem_req.wdata),
    .raddr(mem_req.raddr[ADDR_W-1:0]),
    .rdata(mem_rdata)
  );

  assign out_word0 = out_key.w0;
  assign out_word1 = out_key.w1;
  assign out_word2 = out_key.w2;
  assign out_word3 = out_key.w3;
  assign out_tail  = out_key.tail;

endmodule
